// File: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and codes shared by the text console writer: operation codes,
// control characters and the request and response transfer structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam int unsigned TAB_STEP = 8;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  char_code;
		logic [7:0]  attribute;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_value;
		logic        scrolled;
	} rsp_t;

	function automatic logic [15:0] blank_cell(input logic [7:0] attr);
		return {attr, CH_SPACE};
	endfunction

endpackage

// File: hw/rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: a ROWS x COLUMNS cell memory with a cursor.
// Put, clear and read operations; one response per request.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   req     | in        | req_valid/req_stall  | tcw_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_stall  | tcw_pkg::rsp_t
//
// One request at a time. Read passes through EXEC, READ and RESP to a loaded
// response register, put and opcode 3 through EXEC and RESP. A put that
// scrolls also moves the rows up and blanks the last row, a clear blanks
// every cell: the single write port of the cell memory moves or blanks
// one cell per cycle. After reset a sweep zeroes the memory; req_stall
// stays high meanwhile. A stalled response holds in its register while the
// next request is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tcw_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tcw_pkg::rsp_t  rsp
);

	localparam int unsigned CELLS = ROWS * COLUMNS;
	localparam int unsigned MOVE  = (ROWS - 1) * COLUMNS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned CNTW  = $clog2(CELLS + 1);
	localparam int unsigned CLW   = $clog2(COLUMNS);
	localparam int unsigned RW    = $clog2(ROWS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_READ   = 6'b000100,
		S_SCROLL = 6'b001000,
		S_FILL   = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t              state_q;
	tcw_pkg::req_t       req_q;
	logic [CLW-1:0]      col_q;
	logic [RW-1:0]       row_q;
	logic [CNTW-1:0]     cnt_q;
	logic [15:0]         fill_val_q;
	logic [15:0]         value_q;
	logic                scrolled_q;
	logic                pending_q;
	logic                index_ok_q;
	tcw_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;

	logic [15:0]         mem [CELLS];
	logic [15:0]         rd_q;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [15:0]         mem_wd;
	logic [AW-1:0]       mem_ra;

	logic [CLW:0]        col_ext;
	logic [CLW:0]        col_n;
	logic                row_inc;
	logic [RW:0]         row_n;
	logic                put_we;
	logic [CLW-1:0]      put_wcol;
	logic [15:0]         put_wd;
	logic                put_scroll;
	logic [AW-1:0]       put_wa;
	logic [AW-1:0]       pos_lin;
	logic                rsp_free;
	logic                accept;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		col_ext  = {1'b0, col_q};
		col_n    = col_ext;
		row_inc  = 1'b0;
		put_we   = 1'b0;
		put_wcol = col_q;
		put_wd   = {req_q.attribute, req_q.char_code};
		case (req_q.char_code)
			tcw_pkg::CH_NEWLINE: begin
				col_n   = '0;
				row_inc = 1'b1;
			end
			tcw_pkg::CH_RETURN: begin
				col_n = '0;
			end
			tcw_pkg::CH_TAB: begin
				col_n = (col_ext + (CLW+1)'(tcw_pkg::TAB_STEP))
					& ~(CLW+1)'(tcw_pkg::TAB_STEP - 1);
			end
			tcw_pkg::CH_BACKSPACE: begin
				if (col_q != '0) begin
					col_n    = col_ext - (CLW+1)'(1);
					put_we   = 1'b1;
					put_wcol = col_q - CLW'(1);
					put_wd   = tcw_pkg::blank_cell(req_q.attribute);
				end
			end
			default: begin
				put_we = 1'b1;
				col_n  = col_ext + (CLW+1)'(1);
			end
		endcase
		if (col_n >= (CLW+1)'(COLUMNS)) begin
			col_n   = '0;
			row_inc = 1'b1;
		end
		row_n      = {1'b0, row_q} + (RW+1)'(row_inc);
		put_scroll = (row_n >= (RW+1)'(ROWS));
		put_wa     = AW'(row_q) * AW'(COLUMNS) + AW'(put_wcol);
		pos_lin    = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(cnt_q);
		mem_wd = fill_val_q;
		mem_ra = AW'(cnt_q) + AW'(COLUMNS);
		unique case (state_q) inside
			S_EXEC: begin
				mem_ra = AW'(req_q.cell_index);
				if (req_q.opcode == tcw_pkg::OP_PUT) begin
					mem_we = put_we;
					mem_wa = put_wa;
					mem_wd = put_wd;
				end
			end
			S_SCROLL: begin
				mem_we = (cnt_q != '0);
				mem_wa = AW'(cnt_q) - AW'(1);
				mem_wd = rd_q;
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_IDLE, S_READ, S_RESP: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			req_q       <= '0;
			cnt_q       <= '0;
			fill_val_q  <= '0;
			value_q     <= '0;
			scrolled_q  <= 1'b0;
			index_ok_q  <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			pending_q   <= 1'b0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q     <= req;
						pending_q <= 1'b1;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					value_q    <= '0;
					scrolled_q <= (req_q.opcode == tcw_pkg::OP_PUT) && put_scroll;
					case (req_q.opcode)
						tcw_pkg::OP_PUT: begin
							col_q <= col_n[CLW-1:0];
							if (put_scroll) begin
								row_q      <= RW'(ROWS - 1);
								fill_val_q <= tcw_pkg::blank_cell(req_q.attribute);
								cnt_q      <= '0;
								state_q    <= S_SCROLL;
							end else begin
								row_q   <= row_n[RW-1:0];
								state_q <= S_RESP;
							end
						end
						tcw_pkg::OP_CLEAR: begin
							col_q      <= '0;
							row_q      <= '0;
							fill_val_q <= tcw_pkg::blank_cell(req_q.attribute);
							cnt_q      <= '0;
							state_q    <= S_FILL;
						end
						tcw_pkg::OP_READ: begin
							index_ok_q <= (32'(req_q.cell_index) < CELLS);
							state_q    <= S_READ;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_READ: begin
					value_q <= index_ok_q ? rd_q : '0;
					state_q <= S_RESP;
				end
				S_SCROLL: begin
					if (cnt_q == CNTW'(MOVE)) begin
						state_q <= S_FILL;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				S_FILL: begin
					if (cnt_q == CNTW'(CELLS - 1)) begin
						state_q <= pending_q ? S_RESP : S_IDLE;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_q.cursor_pos <= 11'(pos_lin);
						rsp_q.cell_value <= value_q;
						rsp_q.scrolled   <= scrolled_q;
						rsp_valid_q      <= 1'b1;
						pending_q        <= 1'b0;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: dv/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Watches the request and response channels of the text console writer.
// Keeps a shadow screen and cursor, predicts one response for each request
// transfer and compares every response transfer, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  tcw_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  tcw_pkg::rsp_t rsp,
	output int            mismatches,
	output int            pending_results
);

	localparam int unsigned CELLS = ROWS * COLUMNS;

	logic [15:0]   shadow_screen [CELLS];
	int unsigned   cur_col;
	int unsigned   cur_row;
	tcw_pkg::rsp_t predicted_q [$];

	function automatic tcw_pkg::rsp_t apply_request(input tcw_pkg::req_t r);
		tcw_pkg::rsp_t res;
		logic [15:0]   blank;
		int unsigned   lin;
		res = '0;
		blank = {r.attribute, tcw_pkg::CH_SPACE};
		case (tcw_pkg::op_t'(r.opcode))
			tcw_pkg::OP_PUT: begin
				case (r.char_code)
					tcw_pkg::CH_NEWLINE: begin
						cur_col = 0;
						cur_row++;
					end
					tcw_pkg::CH_RETURN: begin
						cur_col = 0;
					end
					tcw_pkg::CH_TAB: begin
						cur_col = (cur_col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
					end
					tcw_pkg::CH_BACKSPACE: begin
						if (cur_col > 0) begin
							cur_col--;
							shadow_screen[cur_row * COLUMNS + cur_col] = blank;
						end
					end
					default: begin
						shadow_screen[cur_row * COLUMNS + cur_col] = {r.attribute, r.char_code};
						cur_col++;
					end
				endcase
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= ROWS) begin
					for (int i = 0; i < CELLS - COLUMNS; i++)
						shadow_screen[i] = shadow_screen[i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						shadow_screen[i] = blank;
					cur_row = ROWS - 1;
					res.scrolled = 1'b1;
				end
			end
			tcw_pkg::OP_CLEAR: begin
				foreach (shadow_screen[i])
					shadow_screen[i] = blank;
				cur_col = 0;
				cur_row = 0;
			end
			tcw_pkg::OP_READ: begin
				if (r.cell_index < CELLS)
					res.cell_value = shadow_screen[r.cell_index];
			end
			default: ;
		endcase
		lin = cur_row * COLUMNS + cur_col;
		res.cursor_pos = lin[10:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("[%0t] tcw_checker: %s mismatch, expected 0x%0h, got 0x%0h",
			$time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tcw_pkg::rsp_t want;
		if (!arst_n) begin
			foreach (shadow_screen[i])
				shadow_screen[i] = '0;
			cur_col = 0;
			cur_row = 0;
			predicted_q.delete();
			mismatches = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_q.size() == 0) begin
					report_mismatch("unexpected response", 0, 32'(rsp));
				end else begin
					want = predicted_q.pop_front();
					if (rsp.cursor_pos !== want.cursor_pos)
						report_mismatch("cursor_pos", 32'(want.cursor_pos),
							32'(rsp.cursor_pos));
					if (rsp.cell_value !== want.cell_value)
						report_mismatch("cell_value", 32'(want.cell_value),
							32'(rsp.cell_value));
					if (rsp.scrolled !== want.scrolled)
						report_mismatch("scrolled", 32'(want.scrolled), 32'(rsp.scrolled));
				end
			end
			if (req_valid && !req_stall)
				predicted_q.push_back(apply_request(req));
		end
		pending_results <= predicted_q.size();
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the text console writer with a short directed sequence followed by
// random bursts of text lines, newline runs, reads, clears and stray
// requests. Both channels idle at random; the response side once holds off
// for a long stretch and the request side waits for all responses mid-run and at the end.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned COLUMNS = 80;
	localparam int unsigned ROWS    = 25;
	localparam int unsigned CELLS   = ROWS * COLUMNS;

	localparam int ITEM_TOTAL     = 1300;
	localparam int HOLD_AT        = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int PAUSE_AT       = 700;
	localparam int TAIL_CYCLES    = 2100;
	localparam int WATCHDOG_LIMIT = 25000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	tcw_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	tcw_pkg::rsp_t rsp;

	int mismatches;
	int pending_results;
	int sent_count  = 0;
	int idle_cycles = 0;
	bit hold_done   = 1'b0;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	tcw_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.mismatches     (mismatches),
		.pending_results(pending_results)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic tcw_pkg::req_t make_req(input tcw_pkg::op_t op, input logic [7:0] ch,
			input logic [7:0] attr, input logic [10:0] idx);
		tcw_pkg::req_t r;
		r.opcode     = op;
		r.char_code  = ch;
		r.attribute  = attr;
		r.cell_index = idx;
		return r;
	endfunction

	task automatic send_item(input tcw_pkg::req_t r, input bit quiet);
		int gap;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sent_count++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// response side: random stalls, one long hold-off
	initial begin
		int stall_len;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				stall_len = HOLD_CYCLES;
			end else begin
				stall_len = pick_gap();
			end
			if (stall_len > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8))
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int          kind;
		int          pick;
		int          text_len;
		bit          quiet;
		bit          paused;
		logic [7:0]  attr;
		logic [7:0]  ch;
		logic [10:0] idx;
		tcw_pkg::op_t op;
		paused = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		send_item(make_req(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_READ, 8'hFF, 8'hFF, 11'd2047), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, 8'h48, 8'hFF, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, 8'h00, 8'h00, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, 8'hFF, 8'hA5, 11'd2047), 1'b0);
		send_item(make_req(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'h5A, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd2), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 8'h00, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 8'h00, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'h33, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 8'h00, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_NONE, 8'hFF, 8'hFF, 11'd2047), 1'b0);
		send_item(make_req(tcw_pkg::OP_CLEAR, 8'h00, 8'h1F, 11'd0), 1'b0);
		send_item(make_req(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd1000), 1'b0);
		// walk tab stops across a full line to force the wrap
		repeat (COLUMNS / tcw_pkg::TAB_STEP)
			send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 8'h00, 11'd0), 1'b0);

		while (sent_count < ITEM_TOTAL) begin
			if (!paused && sent_count >= PAUSE_AT) begin
				paused = 1'b1;
				wait_drain();
			end
			kind  = $urandom_range(0, 99);
			quiet = ($urandom_range(0, 7) == 0);
			attr  = 8'($urandom_range(0, 255));
			if (kind < 62) begin
				text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
					: $urandom_range(0, 30);
				repeat (text_len) begin
					pick = $urandom_range(0, 99);
					if (pick < 3)
						ch = tcw_pkg::CH_TAB;
					else if (pick < 6)
						ch = tcw_pkg::CH_BACKSPACE;
					else if (pick < 8)
						ch = tcw_pkg::CH_RETURN;
					else
						ch = 8'($urandom_range(0, 255));
					send_item(make_req(tcw_pkg::OP_PUT, ch, attr,
						11'($urandom_range(0, 2047))), quiet);
				end
				pick = $urandom_range(0, 19);
				if (pick < 17)
					send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, attr,
						11'($urandom_range(0, 2047))), quiet);
				else if (pick < 19)
					send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, attr,
						11'($urandom_range(0, 2047))), quiet);
			end else if (kind < 67) begin
				repeat ($urandom_range(2, 10))
					send_item(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, attr,
						11'($urandom_range(0, 2047))), quiet);
			end else if (kind < 87) begin
				repeat ($urandom_range(1, 6)) begin
					pick = $urandom_range(0, 99);
					if (pick < 40)
						idx = 11'($urandom_range(0, CELLS - 1));
					else if (pick < 70)
						idx = 11'($urandom_range((ROWS - 1) * COLUMNS, CELLS - 1));
					else if (pick < 90)
						idx = 11'($urandom_range(0, 2 * COLUMNS - 1));
					else
						idx = 11'($urandom_range(CELLS, 2047));
					send_item(make_req(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), idx), quiet);
				end
			end else if (kind < 89) begin
				send_item(make_req(tcw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), attr,
					11'($urandom_range(0, 2047))), quiet);
			end else if (kind < 92) begin
				send_item(make_req(tcw_pkg::OP_NONE, 8'($urandom_range(0, 255)), attr,
					11'($urandom_range(0, 2047))), quiet);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					op = tcw_pkg::op_t'($urandom_range(0, 3));
					if (op == tcw_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
						op = tcw_pkg::OP_PUT;
					send_item(make_req(op, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047))), quiet);
				end
			end
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: text_console_writer.f
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer.sv
dv/tcw_checker.sv
dv/tb_top.sv
